FILE: rtl/rpa_pkg.sv
// Shared types, codes and default sizes for the refcounted page allocator.
// No dependencies; every other file but rpa_ram imports this package.
package rpa_pkg;

  localparam int NUM_PAGES_DEF  = 32768;
  localparam int COUNT_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int PAGE_W     = 15;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TOP_PAGE_W = 16;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REF   = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE   = 2'd1;

  localparam logic [TOP_PAGE_W-1:0] TOP_PAGE_RST = 16'd32768;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   page;
    logic                page_valid;  // page below NUM_PAGES
    logic                in_range;    // page inside the managed window
  } rpa_op_t;

endpackage

FILE: rtl/rpa_in_if.sv
// Request channel: valid/ready handshake carrying action and page number.
// Depends on rpa_pkg.
interface rpa_in_if;
  import rpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PAGE_W-1:0]   page_number;

  modport source (output valid, output action, output page_number, input ready);
  modport sink   (input valid, input action, input page_number, output ready);
endinterface

FILE: rtl/rpa_out_if.sv
// Result channel: valid/ready handshake carrying one result per request.
// Depends on rpa_pkg.
interface rpa_out_if;
  import rpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAGE_W-1:0]    result_page;
  logic [STATUS_W-1:0]  status;
  logic                 page_released;
  logic [CNT_OUT_W-1:0] new_count;

  modport source (output valid, output result_page, output status,
                  output page_released, output new_count, input ready);
  modport sink   (input valid, input result_page, input status,
                  input page_released, input new_count, output ready);
endinterface

FILE: rtl/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/rpa_queue.sv
// Short FIFO of classified requests between front end and back end.
// Depends on rpa_pkg for the request type.
module rpa_queue #(
  parameter int DEPTH = rpa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rpa_pkg::rpa_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output rpa_pkg::rpa_op_t head_op
);
  import rpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpa_op_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  assign full      = (fill_r == CNT_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head_op   = mem_r[rd_ptr_r];
endmodule

FILE: rtl/rpa_front.sv
// Front end: configuration registers, request acceptance and range check.
// Depends on rpa_pkg and rpa_in_if.
module rpa_front #(
  parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rpa_in_if.sink                         in_ch,
  input  logic                           cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output rpa_pkg::rpa_op_t               q_op
);
  import rpa_pkg::*;

  logic [PAGE_W-1:0]     first_page_r;
  logic [TOP_PAGE_W-1:0] top_page_r;
  logic                  page_valid;
  logic                  in_window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
      top_page_r   <= TOP_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_PAGE: first_page_r <= cfg_data[PAGE_W-1:0];
        CFG_TOP_PAGE:   top_page_r   <= cfg_data[TOP_PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign page_valid = (32'(in_ch.page_number) < 32'(NUM_PAGES));
  assign in_window  = (in_ch.page_number >= first_page_r) &&
                      (TOP_PAGE_W'(in_ch.page_number) < top_page_r);

  // Hold off requests while the count table is being cleared or the queue is full.
  assign in_ch.ready = !clearing && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_op.action     = in_ch.action;
    q_op.page       = in_ch.page_number;
    q_op.page_valid = page_valid;
    q_op.in_range   = page_valid && in_window;
  end
endmodule

FILE: rtl/rpa_back.sv
// Back end: free stack, reference count table, read-modify-write sequencer
// and result register. Depends on rpa_pkg, rpa_out_if and rpa_ram.
module rpa_back #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  rpa_pkg::rpa_op_t q_op,
  output logic             q_pop,
  output logic             clearing,
  rpa_out_if.source        out_ch
);
  import rpa_pkg::*;

  localparam int PG_AW   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [PG_AW-1:0]    clr_r, clr_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  rpa_op_t             op_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]    out_page_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_rel_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  // count RAM ports
  logic                  cnt_we, cnt_re;
  logic [PG_AW-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
  // stack RAM ports
  logic                  stk_we, stk_re;
  logic [PG_AW-1:0]      stk_waddr, stk_raddr;
  logic [PAGE_W-1:0]     stk_rd;

  // execute results
  logic                  exec_fire;
  logic [PAGE_W-1:0]     x_page;
  logic [STATUS_W-1:0]   x_status;
  logic                  x_rel;
  logic [COUNT_BITS-1:0] x_cnt;
  logic                  x_cnt_we;
  logic [PG_AW-1:0]      x_cnt_addr;
  logic [COUNT_BITS-1:0] cur_cnt;

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  rpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (op_r.page),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign cur_cnt   = op_r.page_valid ? cnt_rd : '0;

  // Result of one request, from the count and stack words read when it was popped.
  always_comb begin
    x_page     = op_r.page;
    x_status   = STS_OK;
    x_rel      = 1'b0;
    x_cnt      = cur_cnt;
    x_cnt_we   = 1'b0;
    x_cnt_addr = PG_AW'(op_r.page);
    stk_we     = 1'b0;
    depth_nxt  = depth_r;
    case (op_r.action)
      ACT_ALLOC: begin
        x_cnt = '0;
        if (depth_r == '0) begin
          x_page   = '0;
          x_status = STS_OOM;
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
          x_page    = stk_rd;
          if (32'(stk_rd) < 32'(NUM_PAGES)) begin
            x_cnt_we   = 1'b1;
            x_cnt_addr = PG_AW'(stk_rd);
            x_cnt      = COUNT_BITS'(1);
          end
        end
      end
      ACT_FREE: begin
        if (!op_r.in_range) begin
          x_status = STS_RANGE;
        end else if (cnt_rd > COUNT_BITS'(1)) begin
          x_cnt_we = 1'b1;
          x_cnt    = cnt_rd - COUNT_BITS'(1);
        end else begin
          x_cnt_we = 1'b1;
          x_cnt    = '0;
          if (depth_r == DEPTH_W'(NUM_PAGES)) begin
            x_status = STS_FULL;
          end else begin
            stk_we    = exec_fire;
            depth_nxt = depth_r + DEPTH_W'(1);
            x_rel     = 1'b1;
          end
        end
      end
      ACT_REF: begin
        if (!op_r.in_range) begin
          x_status = STS_RANGE;
        end else begin
          x_cnt_we = 1'b1;
          if (cnt_rd != CNT_MAX) begin
            x_cnt = cnt_rd + COUNT_BITS'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign stk_waddr = PG_AW'(depth_r);
  assign stk_raddr = PG_AW'(depth_r - DEPTH_W'(1));
  assign cnt_raddr = PG_AW'(q_op.page);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    cnt_re    = 1'b0;
    stk_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = x_cnt_addr;
    cnt_wdata = x_cnt;
    case (state_r)
      ST_CLEAR: begin
        // sweep the count table to zero, one entry a cycle
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + PG_AW'(1);
        if (clr_r == PG_AW'(NUM_PAGES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cnt_re    = 1'b1;
          stk_re    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          cnt_we    = x_cnt_we;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        depth_r <= depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
    if (exec_fire) begin
      out_page_r   <= x_page;
      out_status_r <= x_status;
      out_rel_r    <= x_rel;
      out_cnt_r    <= CNT_OUT_W'(x_cnt);
    end
  end

  assign clearing             = (state_r == ST_CLEAR);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_page   = out_page_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.page_released = out_rel_r;
  assign out_ch.new_count     = out_cnt_r;
endmodule

FILE: rtl/refcounted_page_allocator_core.sv
// Refcounted page allocator: LIFO free stack plus per-page reference counts.
// Requests pass through a short queue to a back end that handles one at a time
// with a read-modify-write of the count RAM: the count is read when a request
// is popped, then updated and the result registered once the output is free.
// Reset: synchronous; afterwards the count table is swept to zero with
// in_ch.ready low; config writes are taken meanwhile.
module refcounted_page_allocator_core #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rpa_in_if.sink                         in_ch,
  rpa_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpa_pkg::*;

  logic    clearing;
  logic    q_full, q_push, q_pop, q_valid;
  rpa_op_t q_in_op, q_head_op;

  rpa_front #(.NUM_PAGES(NUM_PAGES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_in_op)
  );

  rpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_op   (q_head_op)
  );

  rpa_back #(.NUM_PAGES(NUM_PAGES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_op     (q_head_op),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready)
    else $error("request accepted during count table sweep");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overflow");

  a_oom_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STS_OOM) |->
      (out_ch.result_page == '0 && out_ch.new_count == '0 && !out_ch.page_released))
    else $error("out-of-memory result carries page data");

  a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.page_released) |->
      (out_ch.status == STS_OK && out_ch.new_count == '0))
    else $error("released page with nonzero count or error status");
`endif
endmodule

FILE: tb/page_alloc_checker.sv
`timescale 1ns / 100ps
// Result checker for the refcounted page allocator: mirrors the free stack,
// the count table and both window registers. Depends on rpa_pkg and the channel interfaces.
module page_alloc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rpa_in_if                              req_mon,
  rpa_out_if                             res_mon,
  input  logic                           cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import rpa_pkg::*;

  localparam int                 PAGES     = NUM_PAGES_DEF;
  localparam logic [CNT_OUT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [PAGE_W-1:0]    page;
    logic [STATUS_W-1:0]  status;
    logic                 released;
    logic [CNT_OUT_W-1:0] count;
  } page_outcome_t;

  logic [PAGE_W-1:0]     free_pages [PAGES];
  logic [CNT_OUT_W-1:0]  page_refs  [PAGES];
  int unsigned           free_depth;
  logic [PAGE_W-1:0]     window_lo;
  logic [TOP_PAGE_W-1:0] window_hi;
  page_outcome_t         outcome_q [$];

  // Apply one request to the mirrored state and return the result it gives.
  function automatic page_outcome_t predict_outcome(logic [ACTION_W-1:0] act,
                                                    logic [PAGE_W-1:0] pg);
    page_outcome_t r;
    logic          managed;
    r.page     = pg;
    r.status   = STS_OK;
    r.released = 1'b0;
    r.count    = '0;
    managed    = (pg >= window_lo) && ({1'b0, pg} < window_hi);
    case (act)
      ACT_ALLOC: begin
        if (free_depth == 0) begin
          r.page   = '0;
          r.status = STS_OOM;
        end else begin
          free_depth--;
          r.page = free_pages[free_depth];
          page_refs[r.page] = CNT_OUT_W'(1);
          r.count = CNT_OUT_W'(1);
        end
      end
      ACT_FREE: begin
        if (!managed) begin
          r.status = STS_RANGE;
          r.count  = page_refs[pg];
        end else if (page_refs[pg] > CNT_OUT_W'(1)) begin
          page_refs[pg] = page_refs[pg] - CNT_OUT_W'(1);
          r.count = page_refs[pg];
        end else begin
          // a count already at zero is pushed again, like a count of one
          page_refs[pg] = '0;
          if (free_depth >= PAGES) begin
            r.status = STS_FULL;
          end else begin
            free_pages[free_depth] = pg;
            free_depth++;
            r.released = 1'b1;
          end
        end
      end
      ACT_REF: begin
        if (!managed) begin
          r.status = STS_RANGE;
          r.count  = page_refs[pg];
        end else begin
          if (page_refs[pg] != COUNT_TOP) page_refs[pg] = page_refs[pg] + CNT_OUT_W'(1);
          r.count = page_refs[pg];
        end
      end
      default: r.count = page_refs[pg];
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    page_outcome_t want;
    page_outcome_t got;
    if (!rst_n) begin
      free_depth = 0;
      window_lo  = '0;
      window_hi  = TOP_PAGE_RST;
      foreach (page_refs[i]) page_refs[i] = '0;
      outcome_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_PAGE) window_lo = cfg_data[PAGE_W-1:0];
        else if (cfg_index == CFG_TOP_PAGE) window_hi = cfg_data;
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.result_page, res_mon.status, res_mon.page_released,
                res_mon.new_count};
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat page=%0d status=%0d released=%0d count=%0d",
                   $time, got.page, got.status, got.released, got.count);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch expected page=%0d status=%0d released=%0d count=%0d",
                     $time, want.page, want.status, want.released, want.count);
            $display("%0t:                 actual   page=%0d status=%0d released=%0d count=%0d",
                     $time, got.page, got.status, got.released, got.count);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        outcome_q.push_back(predict_outcome(req_mon.action, req_mon.page_number));
    end
    pending = outcome_q.size();
  end

endmodule

FILE: tb/refcounted_page_allocator_core_test.sv
`timescale 1ns / 100ps
// Top of the page allocator testbench: clock, reset, register writes, request and
// back-pressure stimulus, verdict. Depends on rpa_pkg, the interfaces, core and checker.
module refcounted_page_allocator_core_test;
  import rpa_pkg::*;

  localparam int                  CYCLE_LIMIT   = 1_000_000;
  localparam int                  RAND_PER_WIN  = 220;
  localparam logic [ACTION_W-1:0] ACT_NONE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    sender_idle;
  int                    recv_idle;
  int                    items_sent;
  int                    cycle_count;

  rpa_in_if  req_bus ();
  rpa_out_if res_bus ();

  refcounted_page_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  page_alloc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_bus),
    .res_mon    (res_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Hold the beat until the block takes it; scribble on the payload while idle.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < sender_idle) begin
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACTION_W'($urandom);
      req_bus.page_number <= PAGE_W'($urandom);
      @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.action      <= act;
    req_bus.page_number <= pg;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and let every outstanding result drain before touching registers.
  task automatic settle();
    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input int lo, input int hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_PAGE;
    cfg_data  <= CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index <= CFG_TOP_PAGE;
    cfg_data  <= CFG_DATA_W'(hi);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly alloc/free/ref inside the window, with some edge and stray pages.
  task automatic random_request(input int lo, input int hi);
    int                  pick;
    logic [PAGE_W-1:0]   pg;
    pick = $urandom_range(99);
    pg   = PAGE_W'(lo + $urandom_range(hi - lo - 1));
    if (pick < 35) send_request(ACT_ALLOC, PAGE_W'($urandom));
    else if (pick < 65) send_request(ACT_FREE, pg);
    else if (pick < 88) send_request(ACT_REF, pg);
    else if (pick < 93) send_request(ACT_NONE, PAGE_W'($urandom));
    else begin
      if ($urandom_range(1)) pg = PAGE_W'($urandom);
      else pg = $urandom_range(1) ? PAGE_W'(lo - 1) : PAGE_W'(hi);
      send_request($urandom_range(1) ? ACT_FREE : ACT_REF, pg);
    end
  endtask

  task automatic run_window(input int lo, input int hi, input int n);
    settle();
    write_window(lo, hi);
    for (int p = lo; p < hi; p++) send_request(ACT_FREE, PAGE_W'(p));
    repeat (n) random_request(lo, hi);
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_bus.valid       = 1'b0;
    req_bus.action      = '0;
    req_bus.page_number = '0;
    sender_idle         = 33;
    recv_idle           = 75;
    items_sent          = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty stack, double free, unused action, window extremes.
    send_request(ACT_ALLOC, 15'h7FFF);
    send_request(ACT_REF, 15'd0);
    send_request(ACT_FREE, 15'h7FFF);
    send_request(ACT_ALLOC, 15'd0);
    send_request(ACT_REF, 15'h7FFF);
    send_request(ACT_FREE, 15'h7FFF);
    send_request(ACT_FREE, 15'h7FFF);
    send_request(ACT_FREE, 15'h7FFF);
    send_request(ACT_ALLOC, 15'd0);
    send_request(ACT_ALLOC, 15'd0);
    send_request(ACT_ALLOC, 15'h2AAA);
    send_request(ACT_NONE, 15'h7FFF);
    send_request(ACT_NONE, 15'd0);
    settle();
    write_window(32767, 32768);
    send_request(ACT_FREE, 15'd32766);
    send_request(ACT_REF, 15'd0);
    send_request(ACT_FREE, 15'h7FFF);
    settle();
    write_window(0, 1);
    send_request(ACT_REF, 15'h7FFF);
    send_request(ACT_FREE, 15'd1);
    send_request(ACT_FREE, 15'd0);
    send_request(ACT_ALLOC, 15'h5555);
    send_request(ACT_NONE, 15'h5555);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE_IDX;
    cfg_data  <= '1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    send_request(ACT_REF, 15'd0);

    // Saturate one count, then step it back down once.
    settle();
    write_window(0, 32768);
    repeat (260) send_request(ACT_REF, 15'd12345);
    send_request(ACT_FREE, 15'd12345);

    run_window(100, 164, RAND_PER_WIN);
    sender_idle = 75;
    recv_idle   = 33;
    run_window(32704, 32768, RAND_PER_WIN);
    sender_idle = 0;
    recv_idle   = 0;
    run_window(0, 48, RAND_PER_WIN);

    // Repeated frees of one page push it several times, then pop a few.
    settle();
    write_window(0, 32768);
    repeat (4) send_request(ACT_FREE, 15'd5);
    repeat (3) send_request(ACT_ALLOC, 15'd0);
    repeat (2) send_request(ACT_FREE, 15'd5);

    settle();
    repeat (10) @(negedge clk);
    $display("Drove %0d requests: directed corners, count saturation, three random windows",
             items_sent);
    $display("and repeated frees of one page, under mixed and no back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
